@@ rtl/pid_controller_antiwindup_bias_defines.svh @@
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_bias_defines
// assertion macros shared by the pid controller rtl
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_ANTIWINDUP_BIAS_DEFINES_SVH
`define PID_CONTROLLER_ANTIWINDUP_BIAS_DEFINES_SVH

// same-cycle implication, off while in reset
`define PCAB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define PCAB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pcab_pkg.sv @@
// ----------------------------------------------------------------------------
// pcab_pkg
// shared types and constants of the pid controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcab_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_HALF_T   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_T        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPRING_BIAS = 3'd5;

  typedef struct packed {
    logic [23:0] kp;
    logic [23:0] ki_half_t;
    logic [23:0] kd_t;
  } gains_t;

  typedef struct packed {
    logic signed [15:0] upper;
    logic signed [15:0] lower;
  } limits_t;

  // error terms of one request
  typedef struct packed {
    logic signed [16:0] err;
    logic signed [17:0] err_sum;
    logic signed [16:0] dmeas;
  } err_terms_t;

  // gain products, q.16
  typedef struct packed {
    logic signed [41:0] prop;
    logic signed [42:0] integ_inc;
    logic signed [41:0] deriv;
  } products_t;

endpackage

`default_nettype wire

@@ rtl/pcab_mult.sv @@
// ----------------------------------------------------------------------------
// pcab_mult
// gain multiplier stage: p, i increment and d products
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcab_mult (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     adv,
  input  wire                     valid_in,
  input  pcab_pkg::err_terms_t    terms,
  input  pcab_pkg::gains_t        gains,
  output logic                    valid_out,
  output pcab_pkg::products_t     prod
);

  logic                valid_r;
  pcab_pkg::products_t prod_r, prod_nxt;

  always_comb begin
    prod_nxt.prop      = $signed({1'b0, gains.kp}) * $signed(terms.err);
    prod_nxt.integ_inc = $signed({1'b0, gains.ki_half_t}) * $signed(terms.err_sum);
    prod_nxt.deriv     = $signed({1'b0, gains.kd_t}) * $signed(terms.dmeas);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
    if (adv) begin
      prod_r <= prod_nxt;
    end
  end

  assign valid_out = valid_r;
  assign prod      = prod_r;

endmodule

`default_nettype wire

@@ rtl/pcab_integ.sv @@
// ----------------------------------------------------------------------------
// pcab_integ
// integrator with headroom clamp, then p + i + d sum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pid_controller_antiwindup_bias_defines.svh"

module pcab_integ (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     adv,
  input  wire                     valid_in,
  input  pcab_pkg::products_t     prod,
  input  pcab_pkg::limits_t       lim,
  output logic                    valid_out,
  output logic signed [49:0]      sum
);

  logic               valid_r;
  logic signed [47:0] acc_r, acc_nxt;
  logic signed [49:0] sum_r, sum_nxt;

  logic signed [43:0] hi_e, lo_e, prop_e, max_int, min_int;
  logic signed [48:0] integ_raw, max_e, min_e, upper_cl, lower_cl;

  always_comb begin
    hi_e   = {{12{lim.upper[15]}}, lim.upper, 16'h0000};
    lo_e   = {{12{lim.lower[15]}}, lim.lower, 16'h0000};
    prop_e = {{2{prod.prop[41]}}, prod.prop};

    // headroom left to each limit, zero when none
    max_int = (hi_e > prop_e) ? hi_e - prop_e : '0;
    min_int = (lo_e < prop_e) ? lo_e - prop_e : '0;
    max_e   = {{5{max_int[43]}}, max_int};
    min_e   = {{5{min_int[43]}}, min_int};

    integ_raw = {acc_r[47], acc_r} + {{6{prod.integ_inc[42]}}, prod.integ_inc};
    // upper bound first, lower bound wins when they cross
    upper_cl  = (integ_raw > max_e) ? max_e : integ_raw;
    lower_cl  = (upper_cl < min_e) ? min_e : upper_cl;
    acc_nxt   = lower_cl[47:0];

    sum_nxt = {{8{prod.prop[41]}}, prod.prop} + {{2{acc_nxt[47]}}, acc_nxt}
            + {{8{prod.deriv[41]}}, prod.deriv};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      acc_r   <= '0;
    end else if (adv) begin
      valid_r <= valid_in;
      if (valid_in) begin
        acc_r <= acc_nxt;
      end
    end
    if (adv) begin
      sum_r <= sum_nxt;
    end
  end

  assign valid_out = valid_r;
  assign sum       = sum_r;

  `PCAB_ASSERT_SAME(a_integ_bound, 1'b1,
    (acc_r[47:42] == 6'h00) || (acc_r[47:42] == 6'h3f),
    "integrator left its clamped range")
  `PCAB_ASSERT_NEXT(a_integ_hold, !(adv && valid_in), $stable(acc_r),
    "integrator moved without a request")

endmodule

`default_nettype wire

@@ rtl/pcab_out.sv @@
// ----------------------------------------------------------------------------
// pcab_out
// spring bias, output saturation and floor to integer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcab_out (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     adv,
  input  wire                     valid_in,
  input  wire signed [49:0]       sum,
  input  pcab_pkg::limits_t       lim,
  input  wire [14:0]              spring_bias,
  output logic                    valid_out,
  output logic signed [15:0]      drive,
  output logic                    saturated
);

  logic               valid_r;
  logic signed [15:0] drive_r, drive_nxt;
  logic               sat_r, sat_nxt;

  logic signed [50:0] bias_e, biased, hi_e, lo_e, hi_cl, lo_cl;

  always_comb begin
    bias_e = {20'h00000, spring_bias, 16'h0000};
    biased = {sum[49], sum} + ((sum > 50'sd0) ? bias_e : '0);
    hi_e   = {{19{lim.upper[15]}}, lim.upper, 16'h0000};
    lo_e   = {{19{lim.lower[15]}}, lim.lower, 16'h0000};
    hi_cl  = (biased > hi_e) ? hi_e : biased;
    lo_cl  = (hi_cl < lo_e) ? lo_e : hi_cl;
    // arithmetic shift by 16 is the floor
    drive_nxt = lo_cl[31:16];
    sat_nxt   = (lo_cl != biased);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
    if (adv) begin
      drive_r <= drive_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign valid_out = valid_r;
  assign drive     = drive_r;
  assign saturated = sat_r;

endmodule

`default_nettype wire

@@ rtl/pid_controller_antiwindup_bias.sv @@
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_bias
// pid position controller with integrator headroom clamp and spring bias
// ----------------------------------------------------------------------------
// pipeline: a request passes the input, multiply, integrate and output
//   registers in turn before out_tvalid rises with its result
// throughput: one request per cycle while out_tready does not hold the result
//   back; the integrator add-and-clamp loop closes within the integrate stage
// reset: rst_n low clears the pipeline, integrator and error history and
//   loads the default gains and limits
`timescale 1ns / 1ps
`default_nettype none

`include "pid_controller_antiwindup_bias_defines.svh"

module pid_controller_antiwindup_bias (
  input  wire         clk,
  input  wire         rst_n,
  // request channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [15:0] setpoint, [31:16] measured
  // result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // [15:0] drive
  output logic        out_tuser,  // [0] saturated
  // configuration write channel
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [31:0] cfg_data
);

  // configuration registers
  logic [23:0]        kp_r, ki_half_t_r, kd_t_r;
  logic signed [15:0] upper_limit_r, lower_limit_r;
  logic [14:0]        spring_bias_r;

  pcab_pkg::gains_t  gains;
  pcab_pkg::limits_t lim;

  // front end history
  logic signed [16:0] last_error_r;
  logic signed [15:0] last_measured_r;

  // input stage
  logic                   s1_valid_r;
  pcab_pkg::err_terms_t   s1_terms_r, s1_terms_nxt;

  logic signed [15:0] setpoint, measured;
  logic               in_acc;
  logic               adv;

  // downstream stage links
  logic                 s2_valid, s3_valid;
  pcab_pkg::products_t  s2_prod;
  logic signed [49:0]   s3_sum;
  logic signed [15:0]   drive;
  logic                 saturated;

  // whole pipeline moves together unless the result is held back
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign setpoint = in_tdata[15:0];
  assign measured = in_tdata[31:16];

  assign gains = '{kp: kp_r, ki_half_t: ki_half_t_r, kd_t: kd_t_r};
  assign lim   = '{upper: upper_limit_r, lower: lower_limit_r};

  // error, trapezoid error sum and measurement delta
  always_comb begin
    s1_terms_nxt.err     = {setpoint[15], setpoint} - {measured[15], measured};
    s1_terms_nxt.err_sum = {s1_terms_nxt.err[16], s1_terms_nxt.err}
                         + {last_error_r[16], last_error_r};
    s1_terms_nxt.dmeas   = {measured[15], measured} - {last_measured_r[15], last_measured_r};
  end

  // config write; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r          <= 24'd436470;
      ki_half_t_r   <= 24'd390;
      kd_t_r        <= 24'd1028;
      upper_limit_r <= 16'sd1000;
      lower_limit_r <= -16'sd1000;
      spring_bias_r <= 15'd120;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcab_pkg::REG_KP:          kp_r          <= cfg_data[23:0];
        pcab_pkg::REG_KI_HALF_T:   ki_half_t_r   <= cfg_data[23:0];
        pcab_pkg::REG_KD_T:        kd_t_r        <= cfg_data[23:0];
        pcab_pkg::REG_UPPER_LIMIT: upper_limit_r <= cfg_data[15:0];
        pcab_pkg::REG_LOWER_LIMIT: lower_limit_r <= cfg_data[15:0];
        pcab_pkg::REG_SPRING_BIAS: spring_bias_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // input register and error history, updated on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      last_error_r    <= '0;
      last_measured_r <= '0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
      if (in_tvalid) begin
        last_error_r    <= s1_terms_nxt.err;
        last_measured_r <= measured;
      end
    end
    if (in_acc) begin
      s1_terms_r <= s1_terms_nxt;
    end
  end

  pcab_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .valid_in  (s1_valid_r),
    .terms     (s1_terms_r),
    .gains     (gains),
    .valid_out (s2_valid),
    .prod      (s2_prod)
  );

  pcab_integ u_integ (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .valid_in  (s2_valid),
    .prod      (s2_prod),
    .lim       (lim),
    .valid_out (s3_valid),
    .sum       (s3_sum)
  );

  pcab_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .valid_in    (s3_valid),
    .sum         (s3_sum),
    .lim         (lim),
    .spring_bias (spring_bias_r),
    .valid_out   (out_tvalid),
    .drive       (drive),
    .saturated   (saturated)
  );

  assign out_tdata = drive;
  assign out_tuser = saturated;

  // a saturated result sits exactly on a limit
  `PCAB_ASSERT_SAME(a_sat_on_limit, out_tvalid && out_tuser,
    (drive == upper_limit_r) || (drive == lower_limit_r),
    "saturated drive is not at a limit")
  // with ordered limits the drive stays between them
  `PCAB_ASSERT_SAME(a_drive_in_range, out_tvalid && (lower_limit_r <= upper_limit_r),
    (drive <= upper_limit_r) && (drive >= lower_limit_r),
    "drive outside the output limits")

endmodule

`default_nettype wire
